/* src/rrc_pkg.sv */
package rrc_pkg;

    localparam int HASH_W              = 64;
    localparam int CFG_W               = 10;
    localparam int COUNT_W             = 32;
    localparam int DEFAULT_TABLE_DEPTH = 512;
    localparam int ACTIVE_RESET        = 512;

    // stream data widths, rounded up to whole bytes
    localparam int IN_TDATA_W  = ((HASH_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((1 + COUNT_W + 7) / 8) * 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // one hash walking down the chain of cells
    typedef struct packed {
        logic              valid;  // slot carries an item
        logic              done;   // equal entry found, stop inserting
        logic              rec;    // item displaced an entry somewhere
        logic [HASH_W-1:0] data;   // carried value
    } t_token;

endpackage

/* src/rrc_cell.sv */
module rrc_cell
    import rrc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_adv,
    input  logic   i_active,
    input  t_token i_tok,
    output t_token o_tok
);

    logic [HASH_W-1:0] r_entry;
    logic [HASH_W-1:0] n_entry;
    t_token            r_tok;
    t_token            n_tok;

    // swap a larger carried value into this slot, stop on a duplicate
    always_comb begin
        n_entry = r_entry;
        n_tok   = i_tok;
        if (i_tok.valid && i_active && !i_tok.done) begin
            if (i_tok.data > r_entry) begin
                n_entry    = i_tok.data;
                n_tok.data = r_entry;
                n_tok.rec  = 1'b1;
            end else if (i_tok.data == r_entry) begin
                n_tok.done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
            r_tok   <= '0;
        end else if (i_adv) begin
            r_entry <= n_entry;
            r_tok   <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

/* src/rrc_tail.sv */
module rrc_tail
    import rrc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  t_token             i_tok,
    output logic               o_valid,
    output logic               o_rec,
    output logic [COUNT_W-1:0] o_count
);

    logic               r_valid;
    logic               r_rec;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;

    // saturating record count
    always_comb begin
        n_count = r_count;
        if (i_tok.valid && i_tok.rec && (r_count != COUNT_MAX)) begin
            n_count = r_count + COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rec   <= 1'b0;
            r_count <= '0;
        end else if (i_adv) begin
            r_valid <= i_tok.valid;
            if (i_tok.valid) begin
                r_rec   <= i_tok.rec;
                r_count <= n_count;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_rec   = r_rec;
    assign o_count = r_count;

endmodule

/* src/recordinality_record_counter_unit.sv */
// Recordinality record counter. Each input transaction carries one 64-bit hash;
// each output transaction returns {record_count, is_record} for that hash, in
// input order. The table of the largest distinct hashes lives in a chain of
// TABLE_DEPTH cells, sorted largest first; every hash walks the whole chain,
// one cell per cycle, swapping itself into the first smaller active entry and
// carrying the displaced value on, and stopping if it meets an equal entry.
// Hashes follow each other one cell apart, so the unit sustains one
// transaction per cycle while the output does not stall; every hash passes
// through all TABLE_DEPTH cell registers and then the output register,
// whatever active_entries is. A stall on the output freezes the whole chain.
// Reset clears all entries, the count and the pipeline; active_entries resets
// to 512 (clamped to TABLE_DEPTH). Write active_entries only while no
// transaction is in flight; 0 acts as 1 and values above TABLE_DEPTH act as
// TABLE_DEPTH. Entries beyond the active ones keep their values untouched.
module recordinality_record_counter_unit
    import rrc_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration: active_entries
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_W-1:0]       i_cfg_data,
    // input stream
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // [63:0] hash_value
    // output stream
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata    // [0] is_record, [32:1] record_count
);

    localparam int K_W     = $clog2(TABLE_DEPTH + 1);
    localparam int K_RESET = (ACTIVE_RESET > TABLE_DEPTH) ? TABLE_DEPTH : ACTIVE_RESET;

    logic [K_W-1:0]     r_k_eff;
    logic [K_W-1:0]     n_k_eff;
    logic               adv;
    logic               out_valid;
    logic               out_rec;
    logic [COUNT_W-1:0] out_count;
    t_token             tok [TABLE_DEPTH+1];

    // clamp the written register into 1..TABLE_DEPTH
    always_comb begin
        if (i_cfg_data == '0) begin
            n_k_eff = K_W'(1);
        end else if (int'(i_cfg_data) > TABLE_DEPTH) begin
            n_k_eff = K_W'(TABLE_DEPTH);
        end else begin
            n_k_eff = K_W'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_eff <= K_W'(K_RESET);
        end else if (i_cfg_valid) begin
            r_k_eff <= n_k_eff;
        end
    end

    assign o_cfg_ready = 1'b1;

    // advance the chain whenever the output register is free or being drained
    assign adv        = !out_valid || i_m_tready;
    assign o_s_tready = adv;

    // inject a fresh token; an idle input enters as a bubble
    always_comb begin
        tok[0]       = '0;
        tok[0].valid = i_s_tvalid;
        tok[0].data  = i_s_tdata[HASH_W-1:0];
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        rrc_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_adv    (adv),
            .i_active (K_W'(g) < r_k_eff),
            .i_tok    (tok[g]),
            .o_tok    (tok[g+1])
        );
    end

    // hold the result and the running count until the consumer takes it
    rrc_tail u_tail (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_tok   (tok[TABLE_DEPTH]),
        .o_valid (out_valid),
        .o_rec   (out_rec),
        .o_count (out_count)
    );

    assign o_m_tvalid = out_valid;
    assign o_m_tdata  = OUT_TDATA_W'({out_count, out_rec});

`ifndef SYNTHESIS
    // the count never goes backward
    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> out_count >= $past(out_count))
        else $error("record count decreased");

    // a reported record always comes with a nonzero count
    a_record_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && out_rec) |-> (out_count != '0))
        else $error("record reported with zero count");

    // the count moves only when a record leaves the chain
    a_count_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(out_count) |-> $past(adv && tok[TABLE_DEPTH].valid && tok[TABLE_DEPTH].rec))
        else $error("record count changed without a record");
`endif

endmodule

/* tb/tb_recordinality_record_counter_unit.sv */
module tb_recordinality_record_counter_unit
    import rrc_pkg::*;
();

    localparam int TB_DEPTH       = DEFAULT_TABLE_DEPTH;
    localparam int CLK_PERIOD     = 4;
    localparam int TIMEOUT_CYCLES = 200_000;
    localparam int MAX_REPORTS    = 10;

    typedef struct {
        logic               is_record;
        logic [COUNT_W-1:0] count;
    } t_verdict;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_W-1:0]       i_cfg_data  = '0;
    logic                   i_s_tvalid  = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata   = '0;   // [63:0] hash_value
    logic                   o_m_tvalid;
    logic                   i_m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;          // [0] is_record, [32:1] record_count

    // Shadow of the block: sorted table, record count, active_entries setting
    logic [HASH_W-1:0]  top_values [TB_DEPTH];
    logic [COUNT_W-1:0] records_seen = '0;
    logic [CFG_W-1:0]   active_cfg   = CFG_W'(ACTIVE_RESET);
    t_verdict           pending_verdicts [$];
    logic [HASH_W-1:0]  hash_pool [16];

    int mismatch_count     = 0;
    int hashes_sent        = 0;
    int settings_written   = 0;
    int input_stall_cycles = 0;
    int burst_left         = 0;
    int receiver_hold      = 0;
    int duty_left          = 0;
    int duty_pct           = 100;

    recordinality_record_counter_unit #(
        .TABLE_DEPTH (TB_DEPTH)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Clamp the setting the way the block does: zero acts as one, anything
    // above the table depth acts as the full table.
    function automatic int live_entries();
        if (active_cfg == 0) return 1;
        if (active_cfg > TB_DEPTH) return TB_DEPTH;
        return int'(active_cfg);
    endfunction

    // Walk the hash down the active entries: swap with each smaller entry,
    // stop on an equal one. A walk that ends carrying anything but the hash means a record.
    function automatic void predict_record(input logic [HASH_W-1:0] hash);
        logic [HASH_W-1:0] moving;
        logic [HASH_W-1:0] held;
        int                k;
        t_verdict          v;
        moving = hash;
        k      = live_entries();
        for (int i = 0; i < k; i++) begin
            held = top_values[i];
            if (moving > held) begin
                top_values[i] = moving;
                moving        = held;
            end else if (moving == held) begin
                break;
            end
        end
        v.is_record = (moving != hash);
        if (v.is_record && records_seen != COUNT_MAX) records_seen++;
        v.count = records_seen;
        pending_verdicts.push_back(v);
    endfunction

    // Bias hashes toward the interesting spots: duplicates of live entries,
    // neighbors of entries and of the smallest live entry, repeats, extremes.
    function automatic logic [HASH_W-1:0] pick_hash();
        int                sel;
        int                k;
        logic [HASH_W-1:0] entry;
        k     = live_entries();
        sel   = $urandom_range(0, 99);
        entry = top_values[$urandom_range(0, k - 1)];
        if (sel < 30) return {$urandom, $urandom};
        if (sel < 52) return entry;
        if (sel < 65) return entry + HASH_W'($urandom_range(0, 2)) - 1;
        if (sel < 75) return top_values[k - 1] + HASH_W'($urandom_range(0, 2)) - 1;
        if (sel < 85) return hash_pool[$urandom_range(0, 15)];
        if (sel < 89) return '0;
        if (sel < 93) return '1;
        if (sel < 97) return HASH_W'(1) << $urandom_range(0, HASH_W - 1);
        return HASH_W'($urandom_range(1, 15));
    endfunction

    // Offer one hash and hold it until the block takes it. Bursts of random
    // length are separated by random gaps, with occasional long gap-free runs.
    task automatic send_hash(input logic [HASH_W-1:0] hash);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 20);
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= hash;
        do begin
            @(posedge i_clk);
            if (!o_s_tready) input_stall_cycles++;
        end while (!o_s_tready);
        predict_record(hash);
        hashes_sent++;
    endtask

    // Drop valid and wait until every outstanding result is back.
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write active_entries with the block idle.
    task automatic write_active_entries(input logic [CFG_W-1:0] value);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        active_cfg = value;
        settings_written++;
    endtask

    task automatic send_random_hashes(input int count);
        repeat (count) send_hash(pick_hash());
    endtask

    // Result side: stall with a randomly redrawn duty cycle, 100 percent
    // included; a requested hold overrides it.
    always @(posedge i_clk) begin
        if (receiver_hold > 0) begin
            i_m_tready <= 1'b0;
            receiver_hold--;
        end else begin
            if (duty_left == 0) begin
                case ($urandom_range(0, 4))
                    0, 1:    duty_pct = 100;
                    2:       duty_pct = 75;
                    3:       duty_pct = 50;
                    default: duty_pct = 20;
                endcase
                duty_left = $urandom_range(16, 128);
            end
            duty_left--;
            i_m_tready <= ($urandom_range(1, 100) <= duty_pct);
        end
    end

    // Compare every result transaction with the oldest prediction.
    always @(posedge i_clk) begin
        t_verdict           want;
        logic               got_record;
        logic [COUNT_W-1:0] got_count;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_record = o_m_tdata[0];
            got_count  = o_m_tdata[COUNT_W:1];
            if (pending_verdicts.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: is_record=%0b record_count=%0d",
                             got_record, got_count);
            end else begin
                want = pending_verdicts.pop_front();
                if (got_record !== want.is_record || got_count !== want.count) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"mismatch: is_record exp %0b got %0b, ",
                                  "record_count exp %0d got %0d"},
                                 want.is_record, got_record, want.count, got_count);
                end
            end
        end
    end

    // Empty table: zero never records, nonzero values fill zero slots,
    // duplicates are rejected, extreme bit patterns.
    task automatic test_empty_slots();
        send_hash('0);
        send_hash(64'h1);
        send_hash(64'h1);
        send_hash('1);
        send_hash('1);
        send_hash(64'h8000_0000_0000_0000);
        send_hash(64'h5555_5555_5555_5555);
        send_hash(64'hAAAA_AAAA_AAAA_AAAA);
        send_hash(64'h7FFF_FFFF_FFFF_FFFF);
    endtask

    // A setting of zero keeps a single entry, which already holds the maximum.
    task automatic test_zero_setting();
        write_active_entries('0);
        send_hash('0);
        send_hash(64'h2);
        send_hash('1);
    endtask

    // All-ones setting clamps to the full table.
    task automatic test_oversize_setting();
        write_active_entries('1);
        send_hash(64'h0000_0001_0000_0000);
        send_hash(64'h1);
        send_hash(64'h0000_0001_0000_0000);
    endtask

    // Shrink to three entries, then grow back: parked entries must return
    // untouched, so a duplicate of one is no record.
    task automatic test_shrink_regrow();
        write_active_entries(CFG_W'(3));
        send_hash(64'hC000_0000_0000_0000);
        send_hash(64'h2);
        send_hash(top_values[2]);
        write_active_entries(CFG_W'(TB_DEPTH));
        send_hash(top_values[5]);
        send_hash(64'h3);
    endtask

    // Random hashes under a range of settings, smallest and largest included.
    task automatic test_random_settings();
        logic [CFG_W-1:0] settings [6];
        settings = '{CFG_W'(1), CFG_W'(2), CFG_W'(17), CFG_W'(TB_DEPTH - 1),
                     CFG_W'(1000), CFG_W'($urandom_range(1, 1023))};
        foreach (settings[i]) begin
            write_active_entries(settings[i]);
            send_random_hashes(95);
        end
    endtask

    // Freeze the result side long enough that the chain fills and the input
    // side stalls while hashes keep being offered.
    task automatic test_output_backpressure();
        write_active_entries(CFG_W'(64));
        receiver_hold = 3 * TB_DEPTH;
        send_random_hashes(600);
    endtask

    initial begin
        for (int i = 0; i < TB_DEPTH; i++) top_values[i] = '0;
        for (int i = 0; i < 16; i++) hash_pool[i] = {$urandom, $urandom};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_slots();
        test_zero_setting();
        test_oversize_setting();
        test_shrink_regrow();
        test_random_settings();
        test_output_backpressure();

        // Let any stray result show up before closing the books.
        drain_results();
        repeat (TB_DEPTH + 16) @(posedge i_clk);
        if (pending_verdicts.size() != 0) begin
            mismatch_count += pending_verdicts.size();
            $display("%0d results never arrived", pending_verdicts.size());
        end

        $display("run covered %0d hashes (%0d records) over %0d active_entries settings",
                 hashes_sent, records_seen, settings_written);
        $display("input side stalled %0d cycles; %0d mismatches",
                 input_stall_cycles, mismatch_count);
        if (mismatch_count == 0) begin
            $display("[recordinality_record_counter_unit] OK");
        end else begin
            $display("[recordinality_record_counter_unit] ERROR");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("timeout after %0d cycles", TIMEOUT_CYCLES);
        $display("[recordinality_record_counter_unit] ERROR");
        $finish;
    end

endmodule
